@@ src/srlp_pkg.sv @@
// Package for the S-record line parser: word types, parser state, error codes
// and the character decode helpers. No dependencies.

package srlp_pkg;

    localparam int LINE_NUMBER_BITS_DEFAULT = 32;

    localparam logic [9:0] POS_LIMIT = 10'd1023;
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] SUM_MASK  = 8'hFF;

    // Per-line fault flags.
    localparam int FLAG_NO_S  = 0;
    localparam int FLAG_TYPE  = 1;
    localparam int FLAG_COUNT = 2;
    localparam int FLAG_HEX   = 3;

    localparam logic RESULT_DATA   = 1'b0;
    localparam logic RESULT_REPORT = 1'b1;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_NO_S,
        ERR_SHORT,
        ERR_TYPE,
        ERR_COUNT_HEX,
        ERR_LENGTH,
        ERR_HEX,
        ERR_CHECKSUM
    } err_code_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } in_word_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_value;
        logic [7:0]  byte_index;
        logic [3:0]  record_kind;
        logic [31:0] record_address;
        logic        sum_ok;
        logic [2:0]  error_code;
        logic [31:0] line_index;
    } out_word_t;

    typedef struct packed {
        logic [9:0]  char_position;
        logic [7:0]  count_byte;
        logic [3:0]  kind_digit;
        logic [31:0] address_accum;
        logic [7:0]  byte_sum;
        logic [3:0]  high_nibble;
        logic [7:0]  stored_checksum;
        logic [3:0]  fault_flags;
    } line_state_t;

    typedef struct packed {
        line_state_t state;
        logic        emit;
        out_word_t   result;
    } step_t;

    // Returns {ok, value}; a non-hex character decodes as zero.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        priority if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b1, c[3:0] + 4'd9};
        else
            r = 5'd0;
        return r;
    endfunction

    function automatic logic [2:0] addr_bytes(input logic [3:0] kind);
        logic [2:0] n;
        unique case (kind)
            4'd2, 4'd6, 4'd8: n = 3'd3;
            4'd3, 4'd7:       n = 3'd4;
            default:          n = 3'd2;
        endcase
        return n;
    endfunction

endpackage

@@ src/srlp_decode.sv @@
// Combinational step of the S-record parser: one character or end-of-line
// word applied to the line state. Depends on srlp_pkg.

module srlp_decode (
    input  srlp_pkg::line_state_t state,
    input  srlp_pkg::in_word_t    in_word,
    input  logic                  csum_en,
    input  logic [31:0]           line_no,
    output srlp_pkg::step_t       step
);
    import srlp_pkg::*;

    logic [9:0]  p;
    logic [9:0]  q;
    logic [4:0]  hx;
    logic [7:0]  b;
    logic [7:0]  count_now;
    logic [9:0]  ck;
    logic [2:0]  ab;
    logic [9:0]  addr_end;
    logic [9:0]  idx_diff;
    logic [3:0]  faults;
    err_code_t   err;

    always_comb
    begin
        p         = state.char_position;
        q         = p - 10'd1;
        hx        = hex_digit(in_word.char_code);
        b         = {state.high_nibble, hx[3:0]};
        ab        = addr_bytes(state.kind_digit);
        addr_end  = 10'd4 + {6'd0, ab, 1'b0};
        count_now = (q == 10'd2) ? b : state.count_byte;
        ck        = {1'b0, count_now, 1'b0} + 10'd2;
        idx_diff  = q - addr_end;
        faults    = state.fault_flags;
        err       = ERR_OK;

        step        = '0;
        step.state  = state;

        if (!in_word.end_of_line)
        begin
            if (p != POS_LIMIT)
            begin
                step.state.char_position = p + 10'd1;
                if (p == 10'd0)
                begin
                    if (in_word.char_code != CHAR_S)
                        faults[FLAG_NO_S] = 1'b1;
                end
                else if (p == 10'd1)
                begin
                    if (in_word.char_code >= 8'h30 && in_word.char_code <= 8'h39
                        && in_word.char_code != 8'h34)
                        step.state.kind_digit = in_word.char_code[3:0];
                    else
                    begin
                        step.state.kind_digit = 4'd0;
                        faults[FLAG_TYPE]     = 1'b1;
                    end
                end
                else
                begin
                    if (!hx[4])
                    begin
                        if (p < 10'd4)
                            faults[FLAG_COUNT] = 1'b1;
                        else
                            faults[FLAG_HEX] = 1'b1;
                    end
                    if (!p[0])
                        step.state.high_nibble = hx[3:0];
                    else
                    begin
                        if (q == 10'd2)
                            step.state.count_byte = b;
                        if (q < ck)
                            step.state.byte_sum = (state.byte_sum + b) & SUM_MASK;
                        if (q == ck)
                            step.state.stored_checksum = b;
                        if (q >= 10'd4 && q < addr_end)
                            step.state.address_accum = {state.address_accum[23:0], b};
                        else if (q >= addr_end && q <= {1'b0, count_now, 1'b0}
                                 && faults == 4'd0)
                        begin
                            step.emit                  = 1'b1;
                            step.result.result_kind    = RESULT_DATA;
                            step.result.data_value     = b;
                            step.result.byte_index     = idx_diff[8:1];
                            step.result.record_kind    = state.kind_digit;
                            step.result.record_address = state.address_accum;
                            step.result.line_index     = line_no;
                        end
                    end
                end
                step.state.fault_flags = faults;
            end
        end
        else if (p != 10'd0)
        begin
            // Errors are ranked; the first one that applies is reported.
            priority if (faults[FLAG_NO_S])
                err = ERR_NO_S;
            else if (p < 10'd6)
                err = ERR_SHORT;
            else if (faults[FLAG_TYPE])
                err = ERR_TYPE;
            else if (faults[FLAG_COUNT])
                err = ERR_COUNT_HEX;
            else if (p != 10'd4 + {1'b0, state.count_byte, 1'b0})
                err = ERR_LENGTH;
            else if (faults[FLAG_HEX] || state.count_byte < {5'd0, ab} + 8'd1)
                err = ERR_HEX;
            else if (csum_en && ((~state.byte_sum) & SUM_MASK) != state.stored_checksum)
                err = ERR_CHECKSUM;
            else
                err = ERR_OK;

            step.emit               = 1'b1;
            step.result.result_kind = RESULT_REPORT;
            step.result.record_kind =
                (err == ERR_OK || err >= ERR_COUNT_HEX) ? state.kind_digit : 4'd0;
            step.result.record_address =
                (err == ERR_OK || err == ERR_CHECKSUM) ? state.address_accum : 32'd0;
            step.result.sum_ok      = (err == ERR_OK);
            step.result.error_code  = err;
            step.result.line_index  = line_no;
            step.state              = '0;
        end
    end

endmodule

@@ src/srecord_line_parser_top.sv @@
// Top level of the S-record line parser: line state, line counter, checksum
// enable register and the output register. Depends on srlp_pkg, srlp_decode.

// The parser takes one word per clock unless the input is stalled: a character
// or an end-of-line mark. Each word is fully applied in the cycle it is accepted,
// and any result it causes (a data byte on the second digit of a payload byte,
// or the line report on end-of-line) appears in the output register on the next
// cycle, so the sustained rate is one word per cycle while nothing stalls.
// The input stalls only while a result sits in the output register and the
// downstream side stalls it. Empty lines are counted but give no report.
module srecord_line_parser_top #(
    parameter int LINE_NUMBER_BITS = srlp_pkg::LINE_NUMBER_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  srlp_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output srlp_pkg::out_word_t  out_data,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data
);
    import srlp_pkg::*;

    localparam int LC_BITS = (LINE_NUMBER_BITS < 32) ? LINE_NUMBER_BITS : 32;

    line_state_t        state_reg;
    logic [LC_BITS-1:0] line_count_reg;
    logic [LC_BITS-1:0] line_count_next;
    logic               csum_en_reg;
    logic               out_valid_reg;
    out_word_t          out_data_reg;
    logic               in_accept;
    step_t              step;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The counter holds once it reaches all ones.
    assign line_count_next = (&line_count_reg) ? line_count_reg
                                               : line_count_reg + {{(LC_BITS-1){1'b0}}, 1'b1};

    srlp_decode u_decode (
        .state       (state_reg),
        .in_word     (in_data),
        .csum_en     (csum_en_reg),
        .line_no     (32'(line_count_next)),
        .step        (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            line_count_reg <= '0;
            csum_en_reg    <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                csum_en_reg <= cfg_wr_data;
            if (in_accept)
            begin
                state_reg <= step.state;
                if (in_data.end_of_line)
                    line_count_reg <= line_count_next;
            end
            if (in_accept && step.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && step.emit)
            out_data_reg <= step.result;
    end

endmodule

@@ src/srlp_checker.sv @@
// Port-level checks for the S-record line parser, bound to the top level.
// Depends on srlp_pkg and srecord_line_parser_top.

module srlp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input srlp_pkg::out_word_t out_data
);
    import srlp_pkg::*;

    // A held result word must not change under stall.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // The input side stalls only when a result is stuck at the output.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

    a_data_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == RESULT_DATA
            |-> out_data.error_code == ERR_OK && !out_data.sum_ok)
        else $error("data word carries report fields");

    a_report_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == RESULT_REPORT
            |-> out_data.sum_ok == (out_data.error_code == ERR_OK)
                && out_data.data_value == 8'd0 && out_data.byte_index == 8'd0)
        else $error("report validity disagrees with error code");

    a_report_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == RESULT_REPORT
            && (out_data.error_code == ERR_NO_S || out_data.error_code == ERR_SHORT
                || out_data.error_code == ERR_TYPE)
            |-> out_data.record_kind == 4'd0 && out_data.record_address == 32'd0)
        else $error("early error report carries type or address");

endmodule

bind srecord_line_parser_top srlp_checker u_srlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
